[rtl/bresenham_additive_line_draw_unit_macros.svh]
// Assertion macros shared by the checker of the line draw unit.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef BRESENHAM_ADDITIVE_LINE_DRAW_UNIT_MACROS_SVH
`define BRESENHAM_ADDITIVE_LINE_DRAW_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BALD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line draw unit: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BALD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line draw unit: next-cycle check failed");

`endif

[rtl/bald_pkg.sv]
`timescale 1ns / 1ps
// Package for the additive line draw unit: sizes, register indexes and
// pixel helper functions. No dependencies.
package bald_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int IMG_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int IMG_AW     = $clog2(IMG_DEPTH);

    localparam int COORD_W = 11;
    localparam int DIM_W   = COORD_W + 1;
    localparam int D_W     = COORD_W + 3;
    localparam int PIX_W   = 16;
    localparam int CNT_W   = 12;
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_RESET = 9'd256;

    typedef logic signed [COORD_W-1:0] coord_t;

    // True when (x, y) lies inside the active frame, clamped to the store.
    function automatic logic in_frame(input coord_t x, input coord_t y,
                                      input logic [CFG_W-1:0] fw,
                                      input logic [CFG_W-1:0] fh);
        logic [DIM_W-1:0] xu;
        logic [DIM_W-1:0] yu;
        xu = DIM_W'($unsigned(x));
        yu = DIM_W'($unsigned(y));
        return !x[COORD_W-1] && !y[COORD_W-1]
            && (xu < DIM_W'(fw)) && (xu < DIM_W'(MAX_WIDTH))
            && (yu < DIM_W'(fh)) && (yu < DIM_W'(MAX_HEIGHT));
    endfunction

    // Row-major store address of an in-frame pixel.
    function automatic logic [IMG_AW-1:0] pix_addr(input coord_t x, input coord_t y);
        logic [COORD_W-1:0] xu;
        logic [COORD_W-1:0] yu;
        xu = $unsigned(x);
        yu = $unsigned(y);
        return IMG_AW'(yu) * IMG_AW'(MAX_WIDTH) + IMG_AW'(xu);
    endfunction

endpackage

[rtl/bresenham_additive_line_draw_unit.sv]
`timescale 1ns / 1ps
// Additive Bresenham line draw unit over a 16-bit pixel image held in one
// RAM of MAX_WIDTH x MAX_HEIGHT words (bald_ram). Uses bald_pkg.
//
// After reset the unit sweeps the image RAM to zero, one word per cycle, so
// in_ready stays low until all MAX_WIDTH*MAX_HEIGHT words (65536 at the
// default size) are cleared; configuration writes are taken during the
// sweep. A draw item (func 0) walks the line from start to end inclusive
// and adds add_value to every visited pixel inside the active frame
// (frame_width x frame_height, clamped to the store), then returns the
// count of pixels updated. A read item (func 1) returns the pixel at the
// start point, or zero when that point lies outside the frame. The walk
// issues the RAM read of pixel i while the write port stores pixel i-1 plus
// the adder, so the single read and single write port of the image RAM set
// the pace. A draw passes the setup states ST_DELTA and ST_INIT, walks its
// max(|dx|,|dy|)+1 pixels in ST_WALK and posts the result from ST_DONE; a
// read passes ST_RD, ST_RDW and ST_DONE. The result sits in an output
// register, so a new item is taken while a result waits for transfer on the
// output channel; a finished item holds until that register frees up.
module bresenham_additive_line_draw_unit
    import bald_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [PIX_W-1:0]   add_value,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   pixel_value,
    output logic [CNT_W-1:0]   pixels_written
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DELTA = 3'd1;
    localparam logic [2:0] ST_INIT  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_RDW   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // control
    logic [2:0]        state_reg, state_next;
    logic              clearing_reg, clearing_next;
    logic [IMG_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]  fw_reg, fw_next;
    logic [CFG_W-1:0]  fh_reg, fh_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;

    // item payload and walk state
    logic              func_reg, func_next;
    coord_t            x_reg, x_next;
    coord_t            y_reg, y_next;
    coord_t            ex_reg, ex_next;
    coord_t            ey_reg, ey_next;
    logic [PIX_W-1:0]  add_reg, add_next;
    logic [COORD_W-1:0] dx_reg, dx_next;
    logic [COORD_W-1:0] dy_reg, dy_next;
    logic              sx_neg_reg, sx_neg_next;
    logic              sy_neg_reg, sy_neg_next;
    logic              x_major_reg, x_major_next;
    logic signed [D_W-1:0] d_reg, d_next;
    logic signed [D_W-1:0] inc_s_reg, inc_s_next;
    logic signed [D_W-1:0] inc_d_reg, inc_d_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PIX_W-1:0]  res_pix_reg, res_pix_next;
    logic [IMG_AW-1:0] pend_addr_reg, pend_addr_next;
    logic [PIX_W-1:0]  pix_out_reg, pix_out_next;
    logic [CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    // RAM ports
    logic              ram_we;
    logic [IMG_AW-1:0] ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IMG_AW-1:0] ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    // datapath helpers
    logic signed [DIM_W-1:0] diff_x, diff_y;
    logic               dx_wins;
    logic [COORD_W-1:0] major, minor;
    logic               hit;
    logic               mv_x, mv_y;
    coord_t             step_x, step_y;
    logic               out_free;
    logic               accept;

    bald_ram #(
        .WIDTH (PIX_W),
        .DEPTH (IMG_DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready       = (state_reg == ST_IDLE) && !clearing_reg;
    assign accept         = in_valid && in_ready;
    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign pixel_value    = pix_out_reg;
    assign pixels_written = cnt_out_reg;

    // Write port: the clearing sweep, else the pending pixel update. The
    // walk never revisits a pixel, so the read of pixel i and the write of
    // pixel i-1 always hit different words.
    assign ram_we    = clearing_reg || pend_valid_reg;
    assign ram_waddr = clearing_reg ? clr_cnt_reg : pend_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : PIX_W'(ram_rdata + add_reg);

    assign hit       = in_frame(x_reg, y_reg, fw_reg, fh_reg);
    assign ram_raddr = pix_addr(x_reg, y_reg);
    assign ram_re    = hit && ((state_reg == ST_WALK) || (state_reg == ST_RD));

    // x is the major axis when |dx| >= |dy|; the deltas hold through the walk
    assign diff_x  = DIM_W'(signed'(ex_reg)) - DIM_W'(signed'(x_reg));
    assign diff_y  = DIM_W'(signed'(ey_reg)) - DIM_W'(signed'(y_reg));
    assign dx_wins = (dx_reg >= dy_reg);
    assign major   = dx_wins ? dx_reg : dy_reg;
    assign minor   = dx_wins ? dy_reg : dx_reg;

    // Diagonal step when the error term is non-negative, else major axis only.
    assign mv_x   = x_major_reg || !d_reg[D_W-1];
    assign mv_y   = !x_major_reg || !d_reg[D_W-1];
    assign step_x = sx_neg_reg ? '1 : COORD_W'(1);
    assign step_y = sy_neg_reg ? '1 : COORD_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        clearing_next   = clearing_reg;
        clr_cnt_next    = clr_cnt_reg;
        fw_next         = fw_reg;
        fh_next         = fh_reg;
        pend_valid_next = 1'b0;
        out_valid_next  = out_valid_reg;
        func_next       = func_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        add_next        = add_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sx_neg_next     = sx_neg_reg;
        sy_neg_next     = sy_neg_reg;
        x_major_next    = x_major_reg;
        d_next          = d_reg;
        inc_s_next      = inc_s_reg;
        inc_d_next      = inc_d_reg;
        remain_next     = remain_reg;
        cnt_next        = cnt_reg;
        res_pix_next    = res_pix_reg;
        pend_addr_next  = pend_addr_reg;
        pix_out_next    = pix_out_reg;
        cnt_out_next    = cnt_out_reg;

        // clearing sweep after reset
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + IMG_AW'(1);
            if (clr_cnt_reg == IMG_AW'(IMG_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_next = cfg_wr_data;
                REG_FRAME_HEIGHT: fh_next = cfg_wr_data;
                default:          ;
            endcase
        end

        // drop the result once the output side takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next    = func;
                    x_next       = start_x;
                    y_next       = start_y;
                    ex_next      = end_x;
                    ey_next      = end_y;
                    add_next     = add_value;
                    cnt_next     = '0;
                    res_pix_next = '0;
                    state_next   = func ? ST_RD : ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                dx_next     = diff_x[DIM_W-1] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
                dy_next     = diff_y[DIM_W-1] ? COORD_W'(-diff_y) : COORD_W'(diff_y);
                sx_neg_next = diff_x[DIM_W-1];
                sy_neg_next = diff_y[DIM_W-1];
                state_next  = ST_INIT;
            end
            ST_INIT:
            begin
                x_major_next = dx_wins;
                d_next       = signed'({2'b00, minor, 1'b0}) - signed'({3'b000, major});
                inc_s_next   = signed'({2'b00, minor, 1'b0});
                inc_d_next   = signed'({2'b00, minor, 1'b0}) - signed'({2'b00, major, 1'b0});
                remain_next  = CNT_W'(major) + CNT_W'(1);
                state_next   = ST_WALK;
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = ram_raddr;
                    cnt_next        = cnt_reg + CNT_W'(1);
                end
                d_next      = d_reg + (d_reg[D_W-1] ? inc_s_reg : inc_d_reg);
                x_next      = x_reg + (mv_x ? step_x : '0);
                y_next      = y_reg + (mv_y ? step_y : '0);
                remain_next = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD:
            begin
                // remember whether the read was in frame
                pend_addr_next = ram_raddr;
                x_major_next   = hit;
                state_next     = ST_RDW;
            end
            ST_RDW:
            begin
                res_pix_next = x_major_reg ? ram_rdata : '0;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pix_out_next   = func_reg ? res_pix_reg : '0;
                    cnt_out_next   = func_reg ? '0 : cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            fw_reg         <= FRAME_RESET;
            fh_reg         <= FRAME_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clearing_reg   <= clearing_next;
            clr_cnt_reg    <= clr_cnt_next;
            fw_reg         <= fw_next;
            fh_reg         <= fh_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        ex_reg        <= ex_next;
        ey_reg        <= ey_next;
        add_reg       <= add_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sx_neg_reg    <= sx_neg_next;
        sy_neg_reg    <= sy_neg_next;
        x_major_reg   <= x_major_next;
        d_reg         <= d_next;
        inc_s_reg     <= inc_s_next;
        inc_d_reg     <= inc_d_next;
        remain_reg    <= remain_next;
        cnt_reg       <= cnt_next;
        res_pix_reg   <= res_pix_next;
        pend_addr_reg <= pend_addr_next;
        pix_out_reg   <= pix_out_next;
        cnt_out_reg   <= cnt_out_next;
    end

endmodule

[rtl/bald_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bald_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/bald_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the additive line draw unit, bound to its top level.
// Uses bald_pkg and the assertion macros header.
`include "bresenham_additive_line_draw_unit_macros.svh"

module bald_checker
    import bald_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [PIX_W-1:0]   pixel_value,
    input logic [CNT_W-1:0]   pixels_written
);

    // a waiting result holds until transfer
    `BALD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_value) && $stable(pixels_written))

    // one item at a time: an accepted item closes the input side
    `BALD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

    // a result is a read value or a draw count, never both
    `BALD_ASSERT_NOW(a_one_kind, out_valid && (pixel_value != '0), pixels_written == '0)

    // a line has at most 2048 pixels
    `BALD_ASSERT_NOW(a_cnt_range, out_valid, pixels_written <= CNT_W'(2048))

endmodule

bind bresenham_additive_line_draw_unit bald_checker u_bald_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_value    (pixel_value),
    .pixels_written (pixels_written)
);
